// ----- rtl/lhrr_pkg.sv -----
package lhrr_pkg;

    // Handshake sequence length and key phase count.
    localparam int unsigned NUM_PACKETS = 17;
    localparam int unsigned KEY_PHASES  = 3;

    localparam logic [4:0] LAST_PACKET    = 5'(NUM_PACKETS - 1);
    localparam logic [1:0] LAST_KEY_PHASE = 2'(KEY_PHASES - 1);
    localparam logic [4:0] RUMBLE_PACKET  = 5'd15;

    localparam logic [9:0] KEY_IDLE    = 10'h3ff;
    localparam logic [9:0] KEY_PRESSED = 10'h30f;

    localparam logic [9:0] TIMEOUT_RESET = 10'd500;
    localparam logic [7:0] ON_CODE_RESET = 8'h26;

    localparam int unsigned CFG_DATA_W = 10;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_FRAME = 3'd1,
        OP_READ  = 3'd2,
        OP_WRITE = 3'd3,
        OP_KEY   = 3'd4
    } t_op;

    typedef enum logic {
        CFG_RUMBLE_TIMEOUT = 1'b0,
        CFG_RUMBLE_ON_CODE = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [2:0] operation;
        logic       logo_seen;
        logic       serial_ready;
        logic [1:0] byte_lane;
        logic [7:0] write_byte;
    } t_item;

    typedef struct packed {
        logic        read_valid;
        logic [31:0] read_word;
        logic        key_valid;
        logic [9:0]  key_word;
        logic        rumble_on;
        logic        serial_irq;
    } t_result;

    typedef struct packed {
        logic [9:0] rumble_timeout_ticks;
        logic [7:0] rumble_on_code;
    } t_cfg;

    // Reply word sent by the accessory for each packet of the handshake.
    function automatic logic [31:0] handshake_word(input logic [4:0] idx);
        logic [31:0] word;
        case (idx)
            5'd0:    word = 32'h0000494e;
            5'd1:    word = 32'hb6b1494e;
            5'd2:    word = 32'hb6b1494e;
            5'd3:    word = 32'hb6b1544e;
            5'd4:    word = 32'habb1544e;
            5'd5:    word = 32'habb14e45;
            5'd6:    word = 32'hb1ba4e45;
            5'd7:    word = 32'hb1ba4f44;
            5'd8:    word = 32'hb0bb4f44;
            5'd9:    word = 32'hb0bb8002;
            5'd10:   word = 32'h10000010;
            5'd11:   word = 32'h20000013;
            5'd12:   word = 32'h30000003;
            5'd13:   word = 32'h30000003;
            5'd14:   word = 32'h30000003;
            5'd15:   word = 32'h30000003;
            5'd16:   word = 32'h30000003;
            default: word = 32'h0;
        endcase
        return word;
    endfunction

endpackage

// ----- rtl/lhrr_stream_if.sv -----
interface lhrr_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/lhrr_core.sv -----
module lhrr_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  lhrr_pkg::t_item i_item,
    input  lhrr_pkg::t_cfg  i_cfg,
    output lhrr_pkg::t_result o_result
);
    import lhrr_pkg::*;

    logic        r_enabled, n_enabled;
    logic        r_rumble_level, n_rumble_level;
    logic        r_logo_flag, n_logo_flag;
    logic [1:0]  r_key_phase, n_key_phase;
    logic [4:0]  r_packet_index, n_packet_index;
    logic [31:0] r_reply_word, n_reply_word;
    logic [31:0] r_receive_word, n_receive_word;
    logic [9:0]  r_rumble_countdown, n_rumble_countdown;

    logic        frame_enabled;
    logic [4:0]  frame_packet;
    logic [4:0]  next_packet;
    logic [4:0]  lane_shift;
    logic [31:0] merged_word;

    assign lane_shift  = {i_item.byte_lane, 3'b000};
    assign merged_word = (r_receive_word & ~(32'h0000_00ff << lane_shift))
                       | ({24'h0, i_item.write_byte} << lane_shift);

    always_comb begin
        n_enabled          = r_enabled;
        n_rumble_level     = r_rumble_level;
        n_logo_flag        = r_logo_flag;
        n_key_phase        = r_key_phase;
        n_packet_index     = r_packet_index;
        n_reply_word       = r_reply_word;
        n_receive_word     = r_receive_word;
        n_rumble_countdown = r_rumble_countdown;
        frame_enabled      = r_enabled;
        frame_packet       = r_packet_index;
        next_packet        = '0;
        o_result           = '0;

        case (i_item.operation)
            OP_TICK: begin
                if (r_rumble_countdown != '0) begin
                    n_rumble_countdown = r_rumble_countdown - 10'd1;
                    if (r_rumble_countdown == 10'd1) begin
                        n_rumble_level = 1'b0;
                    end
                end
            end
            OP_FRAME: begin
                n_logo_flag = i_item.logo_seen;
                if (i_item.logo_seen) begin
                    n_enabled     = 1'b1;
                    n_key_phase   = (r_key_phase >= LAST_KEY_PHASE) ? 2'd0
                                                                    : r_key_phase + 2'd1;
                    frame_enabled = 1'b1;
                    frame_packet  = '0;
                end
                n_packet_index = frame_packet;
                next_packet    = (frame_packet >= LAST_PACKET) ? 5'd0 : frame_packet + 5'd1;
                if (frame_enabled && i_item.serial_ready) begin
                    n_packet_index      = next_packet;
                    n_reply_word        = handshake_word(next_packet);
                    o_result.serial_irq = 1'b1;
                end
            end
            OP_READ: begin
                if (r_enabled) begin
                    o_result.read_valid = 1'b1;
                    o_result.read_word  = r_reply_word;
                end
            end
            OP_WRITE: begin
                if (r_enabled) begin
                    n_receive_word = merged_word;
                    if (i_item.byte_lane == 2'd3 && r_packet_index == RUMBLE_PACKET) begin
                        n_rumble_level = (merged_word[7:0] == i_cfg.rumble_on_code);
                        if (merged_word[7:0] == i_cfg.rumble_on_code) begin
                            n_rumble_countdown = i_cfg.rumble_timeout_ticks;
                        end
                    end
                end
            end
            OP_KEY: begin
                if (r_logo_flag) begin
                    o_result.key_valid = 1'b1;
                    o_result.key_word  = (r_key_phase == LAST_KEY_PHASE) ? KEY_PRESSED
                                                                         : KEY_IDLE;
                end
            end
            default: begin
            end
        endcase

        o_result.rumble_on = n_rumble_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled          <= 1'b0;
            r_rumble_level     <= 1'b0;
            r_logo_flag        <= 1'b0;
            r_key_phase        <= '0;
            r_packet_index     <= '0;
            r_reply_word       <= '0;
            r_receive_word     <= '0;
            r_rumble_countdown <= '0;
        end else if (i_step) begin
            r_enabled          <= n_enabled;
            r_rumble_level     <= n_rumble_level;
            r_logo_flag        <= n_logo_flag;
            r_key_phase        <= n_key_phase;
            r_packet_index     <= n_packet_index;
            r_reply_word       <= n_reply_word;
            r_receive_word     <= n_receive_word;
            r_rumble_countdown <= n_rumble_countdown;
        end
    end

endmodule

// ----- rtl/link_handshake_rumble_responder.sv -----
// Serial link handshake and rumble responder.
//
// Items arrive on the i_item channel and results leave on the o_result
// channel; both use a valid/ready handshake, and every input transfer
// produces exactly one result transfer, in order. The two configuration
// registers (rumble timeout and rumble on code) are written through the
// plain write port and should only change while no item is in flight.
//
// An accepted item is held in an input register, where the state update
// and the result are formed; the result is then captured in the output
// register, which offers it. One item can be taken every cycle as long as
// the receiver takes its results, with a single step of state logic
// between the two registers.
//
// Reset clears the handshake state, restores both configuration registers
// to their defaults and empties both pipeline registers. When the receiver
// stalls, the result holds in the output register, the input register keeps
// the next item, and only then does i_item.ready drop.
module link_handshake_rumble_responder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  lhrr_pkg::t_cfg_index             i_cfg_index,
    input  logic [lhrr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lhrr_stream_if.sink                      i_item,
    lhrr_stream_if.source                    o_result
);
    import lhrr_pkg::*;

    // Configuration registers.
    t_cfg    r_cfg;

    // Input register stage.
    logic    r_s1_valid;
    t_item   r_s1_item;

    // Output register stage.
    logic    r_out_valid;
    t_result r_out_result;

    t_result step_result;
    logic    out_free;
    logic    in_fire;
    logic    step;

    // The output register can take a new result when it is empty or when
    // its current result is being transferred in this cycle.
    assign out_free = !r_out_valid || o_result.ready;
    assign step     = r_s1_valid && out_free;

    assign i_item.ready = !r_s1_valid || out_free;
    assign in_fire      = i_item.valid && i_item.ready;

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rumble_timeout_ticks <= TIMEOUT_RESET;
            r_cfg.rumble_on_code       <= ON_CODE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RUMBLE_TIMEOUT: r_cfg.rumble_timeout_ticks <= i_cfg_data[9:0];
                CFG_RUMBLE_ON_CODE: r_cfg.rumble_on_code       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (step) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_item.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_result <= step_result;
        end
    end

    // The state of the handshake lives in the core and advances once per
    // item, as the item leaves the input register.
    lhrr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_s1_item),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

endmodule

// ----- rtl/lhrr_checker.sv -----
module lhrr_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  lhrr_pkg::t_result i_out_payload
);
    import lhrr_pkg::*;

    // A stalled result must stay offered and unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // A read answer, a key answer and an interrupt never come from one item.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot0({i_out_payload.read_valid, i_out_payload.key_valid,
                                  i_out_payload.serial_irq}))
        else $error("result mixes answers of different operations");

    // Unanswered fields are zero, and a key answer is one of the two key words.
    a_key_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_payload.key_valid
                ? (i_out_payload.key_word == KEY_IDLE || i_out_payload.key_word == KEY_PRESSED)
                : (i_out_payload.key_word == '0))
            && (i_out_payload.read_valid || i_out_payload.read_word == '0))
        else $error("unexpected key or read word");

endmodule

bind link_handshake_rumble_responder lhrr_checker u_lhrr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_payload (o_result.payload)
);
